### sv/work_stealing_task_dispatcher_core_assert.svh
// Assertion macros for the work-stealing task dispatcher.
// No dependencies; included by the top level.
`ifndef WORK_STEALING_TASK_DISPATCHER_CORE_ASSERT_SVH
`define WORK_STEALING_TASK_DISPATCHER_CORE_ASSERT_SVH
// Antecedent implies consequent on the next edge.
`define WSTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
// Condition holds at every edge outside reset.
`define WSTD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`endif

### sv/wstd_pkg.sv
// Shared types and constants for the work-stealing task dispatcher.
// No dependencies.
package wstd_pkg;
  localparam int NumQueues  = 4;
  localparam int QueueDepth = 16;
  localparam int QW = $clog2(NumQueues);
  localparam int PW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);
  localparam int AW = QW + PW;
  localparam int DescW = 40;
  localparam logic [2:0] ActiveReset = 3'd4;
  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef struct packed {
    logic capture;  // latch request, compute queue, issue memory op
    logic finish;   // present result
  } wstd_cmd_t;

  typedef struct packed {
    logic is_fetch;
  } wstd_sts_t;
endpackage

### sv/wstd_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module wstd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/wstd_ctrl.sv
// Controller for the dispatcher: two-step sequencer per transaction.
// Depends on wstd_pkg.
module wstd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output wstd_pkg::wstd_cmd_t cmd
);
  import wstd_pkg::*;
  typedef enum logic [0:0] {S_IDLE, S_DONE} state_t;
  state_t state;

  always_comb begin
    busy = (state != S_IDLE);
    cmd.capture = (state == S_IDLE) && start;
    cmd.finish  = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (start) state <= S_DONE;
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/wstd_dp.sv
// Datapath: queue pointers, round-robin pointer, steal scan and task store.
// Depends on wstd_pkg and wstd_ram.
module wstd_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  wstd_pkg::wstd_cmd_t    cmd,
  output wstd_pkg::wstd_sts_t    sts,
  input  logic [2:0]             active_queues,
  input  logic                   req_type,
  input  logic [1:0]             worker_index,
  input  logic [7:0]             task_handler,
  input  logic [15:0]            task_id,
  input  logic [15:0]            task_arg,
  output logic                   done,
  output logic                   found,
  output logic [7:0]             out_handler,
  output logic [15:0]            out_task_id,
  output logic [15:0]            out_task_arg,
  output logic [1:0]             source_queue,
  output logic [1:0]             target_queue,
  output logic                   push_rejected
);
  import wstd_pkg::*;

  logic [PW-1:0] head [NumQueues];
  logic [PW-1:0] tail [NumQueues];
  logic [CW-1:0] count [NumQueues];
  logic [QW-1:0] next_push_queue;

  logic          r_fetch, r_found, r_rej;
  logic [QW-1:0] r_q;
  logic [DescW-1:0] rdata;

  logic [QW:0]   act;
  logic [QW-1:0] push_q, worker_mod, scan_q;
  logic          scan_hit, full;
  logic [QW:0]   idx;

  always_comb begin
    act = (active_queues == 3'd0) ? (QW+1)'(1) :
          (active_queues > 3'(NumQueues)) ? (QW+1)'(NumQueues) : (QW+1)'(active_queues);
    push_q = ({1'b0, next_push_queue} >= act) ? '0 : next_push_queue;
    full = (count[push_q] >= CW'(QueueDepth));
    // one active queue: every worker maps to queue 0
    worker_mod = (act == (QW+1)'(1)) ? '0 :
                 QW'(({1'b0, worker_index} >= act) ?
                     ({1'b0, worker_index} - act) : {1'b0, worker_index});
    scan_hit = 1'b0;
    scan_q = '0;
    for (int i = NumQueues - 1; i >= 0; i--) begin
      idx = (QW+1)'(worker_mod) + (QW+1)'(i);
      if (idx >= act) idx = idx - act;
      if (i < act && count[idx[QW-1:0]] != '0) begin
        scan_hit = 1'b1;
        scan_q = idx[QW-1:0];
      end
    end
  end

  logic          we;
  logic [AW-1:0] waddr, raddr;
  assign we    = cmd.capture && (req_type == REQ_PUSH) && !full;
  assign waddr = {push_q, tail[push_q]};
  assign raddr = {scan_q, head[scan_q]};

  wstd_ram #(.Width(DescW), .Depth(NumQueues * QueueDepth)) u_store (
    .clk(clk), .we(we), .waddr(waddr),
    .wdata({task_handler, task_id, task_arg}),
    .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NumQueues; q++) begin
        head[q] <= '0; tail[q] <= '0; count[q] <= '0;
      end
      next_push_queue <= '0;
    end else if (cmd.capture) begin
      if (req_type == REQ_PUSH) begin
        next_push_queue <= ((QW+1)'(push_q) + 1'b1 >= act) ? '0 : push_q + 1'b1;
        if (!full) begin
          tail[push_q] <= tail[push_q] + 1'b1;
          count[push_q] <= count[push_q] + 1'b1;
        end
      end else if (scan_hit) begin
        head[scan_q] <= head[scan_q] + 1'b1;
        count[scan_q] <= count[scan_q] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_fetch <= (req_type == REQ_FETCH);
      r_found <= (req_type == REQ_FETCH) && scan_hit;
      r_rej   <= (req_type == REQ_PUSH) && full;
      r_q     <= (req_type == REQ_PUSH) ? push_q : scan_q;
    end
  end

  assign sts.is_fetch  = r_fetch;
  assign done          = cmd.finish;
  assign found         = r_found;
  assign out_handler   = r_found ? rdata[39:32] : '0;
  assign out_task_id   = r_found ? rdata[31:16] : '0;
  assign out_task_arg  = r_found ? rdata[15:0]  : '0;
  assign source_queue  = r_found ? r_q : '0;
  assign target_queue  = r_fetch ? '0 : r_q;
  assign push_rejected = r_rej;
endmodule

### sv/work_stealing_task_dispatcher_core.sv
// Work-stealing task dispatcher, top level.
// Result strobe (done) in the cycle right after the start edge; a new request is taken only after that result.
// This two-step sequence is set by the task store's registered read: capture, then present.
// Steal scan is a combinational rotating priority search over per-queue non-empty flags.
// Reset (rst, synchronous): empty queues, push pointer 0, active_queues 4.
// The receiver cannot stall; each result shows for one cycle only.
module work_stealing_task_dispatcher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [1:0]  worker_index,
  input  logic [7:0]  task_handler,
  input  logic [15:0] task_id,
  input  logic [15:0] task_arg,
  output logic        done,
  output logic        found,
  output logic [7:0]  out_handler,
  output logic [15:0] out_task_id,
  output logic [15:0] out_task_arg,
  output logic [1:0]  source_queue,
  output logic [1:0]  target_queue,
  output logic        push_rejected,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wstd_pkg::*;
  `include "work_stealing_task_dispatcher_core_assert.svh"

  wstd_cmd_t cmd;
  wstd_sts_t sts;
  logic [2:0] active_queues;

  // Config register file: single register at byte address 0.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      active_queues <= ActiveReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      active_queues <= pwdata[2:0];
    end
  end
  assign prdata = (paddr == 2'd0) ? {29'd0, active_queues} : '0;

  wstd_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd));

  wstd_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .active_queues(active_queues),
    .req_type(req_type), .worker_index(worker_index), .task_handler(task_handler),
    .task_id(task_id), .task_arg(task_arg), .done(done), .found(found),
    .out_handler(out_handler), .out_task_id(out_task_id), .out_task_arg(out_task_arg),
    .source_queue(source_queue), .target_queue(target_queue),
    .push_rejected(push_rejected)
  );

  // Every accepted transaction yields exactly one strobe the next cycle.
  `WSTD_ASSERT_NEXT(a_start_done, start && !busy, done)
  // A fetch result never flags a rejected push.
  `WSTD_ASSERT_ALWAYS(a_fetch_no_rej, !(done && sts.is_fetch && push_rejected))
  // A push result never reports a found task.
  `WSTD_ASSERT_ALWAYS(a_push_no_found, !(done && !sts.is_fetch && found))
endmodule

### verif/tb.sv
// Testbench for work_stealing_task_dispatcher_core: random push/fetch traffic,
// scoreboard checking against a behavioral queue model. Depends on wstd_pkg.
`timescale 1ns / 1ps

module tb;
  import wstd_pkg::*;

  localparam logic [1:0] ADDR_ACTIVE = 2'd0;

  typedef struct packed {
    logic        req;
    logic [1:0]  worker;
    logic [7:0]  handler;
    logic [15:0] id;
    logic [15:0] arg;
  } task_req_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  handler;
    logic [15:0] id;
    logic [15:0] arg;
    logic [1:0]  src;
    logic [1:0]  tgt;
    logic        rejected;
  } dispatch_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic req_type = 1'b0;
  logic [1:0] worker_index = '0;
  logic [7:0] task_handler = '0;
  logic [15:0] task_id = '0, task_arg = '0;
  logic done, found, push_rejected;
  logic [7:0] out_handler;
  logic [15:0] out_task_id, out_task_arg;
  logic [1:0] source_queue, target_queue;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  work_stealing_task_dispatcher_core dut (.*);

  always #5 clk = ~clk;

  // Predictor state
  logic [39:0] mdl_store [NumQueues][QueueDepth];
  int unsigned mdl_head [NumQueues];
  int unsigned mdl_tail [NumQueues];
  int unsigned mdl_count [NumQueues];
  int unsigned mdl_next;
  logic [2:0] mdl_active;

  task_req_t pending_reqs[$];
  dispatch_t expected_results[$];
  int errors = 0;
  int n_push = 0, n_fetch = 0, n_steal = 0, n_reject = 0, n_empty = 0;
  int gap = 0;
  logic hold = 1'b0;   // stimulus hold-off, set by the initial block

  function automatic int unsigned act_count();
    int unsigned a;
    a = mdl_active;
    if (a == 0) a = 1;
    if (a > NumQueues) a = NumQueues;
    return a;
  endfunction

  function automatic dispatch_t dispatch_task(task_req_t t);
    dispatch_t r;
    int unsigned a, q;
    r = '0;
    a = act_count();
    if (t.req == REQ_PUSH) begin
      q = mdl_next;
      if (q >= a) q = 0;
      mdl_next = (q + 1 >= a) ? 0 : q + 1;
      r.tgt = q[1:0];
      n_push++;
      if (mdl_count[q] >= QueueDepth) begin
        r.rejected = 1'b1;
        n_reject++;
      end else begin
        mdl_store[q][mdl_tail[q]] = {t.handler, t.id, t.arg};
        mdl_tail[q] = (mdl_tail[q] + 1) % QueueDepth;
        mdl_count[q]++;
      end
      return r;
    end
    n_fetch++;
    for (int i = 0; i < a; i++) begin
      q = (t.worker + i) % a;
      if (mdl_count[q] != 0) begin
        {r.handler, r.id, r.arg} = mdl_store[q][mdl_head[q]];
        mdl_head[q] = (mdl_head[q] + 1) % QueueDepth;
        mdl_count[q]--;
        r.found = 1'b1;
        r.src = q[1:0];
        if (q != t.worker) n_steal++;
        return r;
      end
    end
    n_empty++;
    return r;
  endfunction

  // Driver: launches queued transactions with random gaps.
  always @(posedge clk) begin
    task_req_t t;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // accepted this edge
      t = pending_reqs.pop_front();
      expected_results.push_back(dispatch_task(t));
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap == 0 && !hold && pending_reqs.size() > 0) begin
        t = pending_reqs[0];
        {req_type, worker_index, task_handler, task_id, task_arg} <= t;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && !hold && pending_reqs.size() > 0) begin
      if (gap > 0) gap--;
      else begin
        t = pending_reqs[0];
        {req_type, worker_index, task_handler, task_id, task_arg} <= t;
        start <= 1'b1;
      end
    end
  end

  // Monitor: every done strobe is one result transaction.
  always @(posedge clk) begin
    dispatch_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (found !== e.found) begin
          $error("found: exp %0h got %0h", e.found, found); errors++;
        end
        if (out_handler !== e.handler) begin
          $error("out_handler: exp %0h got %0h", e.handler, out_handler); errors++;
        end
        if (out_task_id !== e.id) begin
          $error("out_task_id: exp %0h got %0h", e.id, out_task_id); errors++;
        end
        if (out_task_arg !== e.arg) begin
          $error("out_task_arg: exp %0h got %0h", e.arg, out_task_arg); errors++;
        end
        if (source_queue !== e.src) begin
          $error("source_queue: exp %0h got %0h", e.src, source_queue); errors++;
        end
        if (target_queue !== e.tgt) begin
          $error("target_queue: exp %0h got %0h", e.tgt, target_queue); errors++;
        end
        if (push_rejected !== e.rejected) begin
          $error("push_rejected: exp %0h got %0h", e.rejected, push_rejected); errors++;
        end
      end
    end
  end

  task automatic add_req(logic req, logic [1:0] w, logic [7:0] h, logic [15:0] id,
                         logic [15:0] arg);
    task_req_t t;
    t.req = req; t.worker = w; t.handler = h; t.id = id; t.arg = arg;
    pending_reqs.push_back(t);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++)
      add_req(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
  endtask

  // Wait until all issued transactions have completed and the block is quiet.
  task automatic drain();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_active(logic [2:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_ACTIVE; pwdata <= {29'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mdl_active = val;
    @(posedge clk);
  endtask

  // Overall timeout
  initial begin
    #3ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [2:0] settings [7];
    settings = '{3'd1, 3'd4, 3'd2, 3'd0, 3'd3, 3'd7, 3'd4};
    for (int q = 0; q < NumQueues; q++) begin
      mdl_head[q] = 0; mdl_tail[q] = 0; mdl_count[q] = 0;
    end
    mdl_next = 0;
    mdl_active = ActiveReset;
    hold = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty fetch, field extremes, pushes, then fetches that include a steal.
    add_req(REQ_FETCH, 2'd3, 8'hff, 16'hffff, 16'hffff);
    add_req(REQ_PUSH, 2'd0, 8'h00, 16'h0000, 16'h0000);
    add_req(REQ_PUSH, 2'd3, 8'hff, 16'hffff, 16'hffff);
    add_req(REQ_PUSH, 2'd1, 8'ha5, 16'h5a5a, 16'hc33c);
    add_req(REQ_FETCH, 2'd3, 8'h00, 16'h0, 16'h0);
    add_req(REQ_FETCH, 2'd2, 8'h00, 16'h0, 16'h0);
    add_req(REQ_FETCH, 2'd0, 8'h00, 16'h0, 16'h0);
    add_req(REQ_FETCH, 2'd1, 8'h00, 16'h0, 16'h0);
    hold = 1'b0;
    drain();
    // Overfill every queue to force rejections, then pause until drained.
    hold = 1'b1;
    for (int i = 0; i < 4 * QueueDepth + 8; i++)
      add_req(REQ_PUSH, 2'd0, i[7:0], ~i[15:0], i[15:0]);
    hold = 1'b0;
    drain();

    // Random phases over several queue counts, including out-of-range values.
    foreach (settings[k]) begin
      write_active(settings[k]);
      hold = 1'b1;
      add_random(127);
      hold = 1'b0;
      drain();
    end
    // Empty the queues at the end through fetches from every worker.
    hold = 1'b1;
    for (int i = 0; i < 80; i++) add_req(REQ_FETCH, i[1:0], 8'h0, 16'h0, 16'h0);
    hold = 1'b0;
    drain();
    repeat (10) @(posedge clk);

    $display("Run: %0d pushes (%0d rejected), %0d fetches (%0d stolen, %0d empty)",
             n_push, n_reject, n_fetch, n_steal, n_empty);
    $display("active_queues set to 1..4 plus out-of-range 0 and 7");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
